// ----- sv/sil_pkg.sv -----
// ============================================================================
// sil_pkg
// Shared types, codes and widths for the sorted insert list.
// ============================================================================
package sil_pkg;

    // Default table depth
    localparam int DEPTH_DEF = 64;

    // Field widths fixed by the item format
    localparam int REQ_W       = 2;
    localparam int COORD_W     = 16;
    localparam int KIND_W      = 4;
    localparam int IMAGE_W     = 16;
    localparam int RIDX_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 6;
    localparam int FILL_W      = 7;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 72;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    // One table entry; x and y are signed Q12.4
    typedef struct packed {
        logic [IMAGE_W-1:0] image;
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } entry_t;

    // One accepted request
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [RIDX_W-1:0] read_index;
        entry_t            entry;
    } req_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic ins_en;
        logic valid;
    } cell_ctl_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_GATHER
    } sil_state_t;

endpackage

// ----- sv/sil_cell.sv -----
// ============================================================================
// sil_cell
// One slot of the sorted chain: holds an entry, compares its key with the
// incoming one and takes either the new entry or its left neighbor's entry.
// ============================================================================
module sil_cell
    import sil_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    prev_entry,
    input  logic      prev_go,
    output entry_t    entry,
    output logic      go
);

    entry_t entry_reg;
    entry_t entry_next;

    // Move right when empty or holding a strictly larger key
    always_comb
    begin
        go = !ctl.valid || ($signed(entry_reg.y) > $signed(new_entry.y));
    end

    // Shift in from the left neighbor, else take the new entry at the boundary
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins_en)
        begin
            if (prev_go)
            begin
                entry_next = prev_entry;
            end
            else if (go)
            begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- sv/sil_gather.sv -----
// ============================================================================
// sil_gather
// Selects one cell by a one-hot vector and returns its index and entry.
// ============================================================================
module sil_gather
    import sil_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic [DEPTH-1:0]         sel,
    input  entry_t                   cells [DEPTH],
    output logic [$clog2(DEPTH)-1:0] idx,
    output entry_t                   data
);

    localparam int IDX_W = $clog2(DEPTH);

    // AND-OR reduce over the selected cell
    always_comb
    begin
        idx  = '0;
        data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i])
            begin
                idx  = idx | IDX_W'(i);
                data = data | cells[i];
            end
        end
    end

endmodule

// ----- sv/sorted_insert_list.sv -----
// ============================================================================
// sorted_insert_list
// Table of entries kept in ascending y order in a chain of compare-and-shift
// cells; supports insert, clear and read by sorted index.
// ============================================================================
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready  | request: type, x, y, kind, image, index
//  m_      | out | m_tvalid/m_tready  | result: status, slot, entry, fill
//
//  Each item passes the states accept (idle), apply, in which every cell
//  compares and shifts at once, and gather, which gathers the selected cell
//  into the output register. The gather state stalls while m_tready is
//  low and the output register still holds a result. A new item is accepted
//  while a result waits. Reset clears the entry count and the handshake;
//  cell contents are left undefined and are never read before written.
//
module sorted_insert_list
    import sil_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: pos_x[15:0], pos_y[31:16], tile_kind[35:32], image_id[51:36],
    //          read_index[57:52], zero pad
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [REQ_W-1:0]       s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: slot[5:0], out_x[21:6], out_y[37:22], out_kind[41:38],
    //          out_image[57:42], fill[64:58], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: status[1:0]
    output logic [STATUS_W-1:0]    m_tuser
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

    sil_state_t state_reg, state_next;
    req_t       req_reg, req_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [DEPTH-1:0]    sel_reg, sel_next;
    logic [STATUS_W-1:0] stat_reg, stat_next;
    logic                     m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0]   m_data_reg, m_data_next;
    logic [STATUS_W-1:0]      m_user_reg, m_user_next;

    entry_t           cells [DEPTH];
    logic [DEPTH-1:0] go;
    logic [DEPTH-1:0] prev_go;
    logic [DEPTH-1:0] bnd;
    logic [DEPTH-1:0] rsel;
    cell_ctl_t        ctl [DEPTH];

    logic        full;
    logic        read_ok;
    logic        ins_en;
    logic        out_load;
    logic [IDX_W-1:0] g_idx;
    entry_t      g_data;
    entry_t      res_entry;
    logic [SLOT_W-1:0] res_slot;

    // Decode the request item
    req_t s_req;
    assign s_req.req_type     = s_tuser;
    assign s_req.entry.x      = s_tdata[15:0];
    assign s_req.entry.y      = s_tdata[31:16];
    assign s_req.entry.kind   = s_tdata[35:32];
    assign s_req.entry.image  = s_tdata[51:36];
    assign s_req.read_index   = s_tdata[57:52];

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign read_ok = (CMP_W'(req_reg.read_index) < CMP_W'(count_reg));
    assign ins_en  = (state_reg == ST_APPLY) && (req_reg.req_type == REQ_INSERT) && !full;

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign ctl[i].ins_en = ins_en;
        assign ctl[i].valid  = (CNT_W'(i) < count_reg);
        if (i == 0)
        begin : g_head
            assign prev_go[i] = 1'b0;
            sil_cell u_cell (
                .clk        (clk),
                .ctl        (ctl[i]),
                .new_entry  (req_reg.entry),
                .prev_entry (req_reg.entry),
                .prev_go    (prev_go[i]),
                .entry      (cells[i]),
                .go         (go[i])
            );
        end
        else
        begin : g_body
            assign prev_go[i] = go[i-1];
            sil_cell u_cell (
                .clk        (clk),
                .ctl        (ctl[i]),
                .new_entry  (req_reg.entry),
                .prev_entry (cells[i-1]),
                .prev_go    (prev_go[i]),
                .entry      (cells[i]),
                .go         (go[i])
            );
        end
        // Insertion boundary and read select
        assign bnd[i]  = go[i] & !prev_go[i];
        assign rsel[i] = (CMP_W'(i) == CMP_W'(req_reg.read_index));
    end

    sil_gather #(.DEPTH(DEPTH)) u_gather (
        .sel   (sel_reg),
        .cells (cells),
        .idx   (g_idx),
        .data  (g_data)
    );

    // Build the result from the gathered cell
    always_comb
    begin
        res_slot  = '0;
        res_entry = '0;
        case (req_reg.req_type)
            REQ_INSERT:
            begin
                if (stat_reg == STAT_OK)
                begin
                    res_slot = SLOT_W'(g_idx);
                end
            end
            REQ_READ:
            begin
                res_slot = req_reg.read_index;
                if (stat_reg == STAT_OK)
                begin
                    res_entry = g_data;
                end
            end
            default:
            begin
                res_slot = '0;
            end
        endcase
    end

    assign out_load = (state_reg == ST_GATHER) && (!m_valid_reg || m_tready);

    // Sequencer and result register
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        count_next   = count_reg;
        sel_next     = sel_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next   = s_req;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                stat_next  = STAT_OK;
                sel_next   = '0;
                state_next = ST_GATHER;
                case (req_reg.req_type)
                    REQ_INSERT:
                    begin
                        if (full)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            sel_next   = bnd;
                        end
                    end
                    REQ_CLEAR:
                    begin
                        count_next = '0;
                    end
                    REQ_READ:
                    begin
                        if (read_ok)
                        begin
                            sel_next = rsel;
                        end
                        else
                        begin
                            stat_next = STAT_RANGE;
                        end
                    end
                    default:
                    begin
                        stat_next = STAT_OK;
                    end
                endcase
            end
            ST_GATHER:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = stat_reg;
                    m_data_next  = {7'd0, FILL_W'(count_reg), res_entry.image,
                                    res_entry.kind, res_entry.y, res_entry.x, res_slot};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        sel_reg    <= sel_next;
        stat_reg   <= stat_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- sv/sil_checker.sv -----
// ============================================================================
// sil_checker
// Port-level checks for the sorted insert list, bound to the top level.
// ============================================================================
module sil_checker
    import sil_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic [REQ_W-1:0]       s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]    m_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Drop ready for the cycle after an item is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // Zero entry fields on an out-of-range read
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_RANGE) |-> (m_tdata[57:6] == '0))
        else $error("out-of-range read returned entry data");

    // Zero slot and entry on a dropped insert
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata[57:0] == '0))
        else $error("dropped insert returned slot or entry data");

endmodule

bind sorted_insert_list sil_checker u_sil_checker (.*);
